// ===== rtl/arm_status_frame_receiver_defines.svh =====
// assertion macros for the arm status frame receiver
// included by the rtl files that carry concurrent checks, no other dependencies
`ifndef ARM_STATUS_FRAME_RECEIVER_DEFINES_SVH
`define ARM_STATUS_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH

`define ASFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("asfr check failed");

`define ASFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("asfr check failed");

`else

`define ASFR_ASSERT_NOW(lbl, clk, rstn, ante, cons)

`define ASFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/asfr_pkg.sv =====
// shared types and constants for the arm status frame receiver
// no dependencies
`default_nettype none

package asfr_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h55;
  localparam logic [7:0] HDR2_BYTE   = 8'hAA;
  localparam logic [7:0] TAIL_BYTE   = 8'h7D;
  localparam logic [7:0] CMD_JOINT   = 8'h06;
  localparam logic [7:0] CMD_VERSION = 8'h09;
  localparam logic [7:0] CMD_UPGRADE = 8'h0A;
  localparam logic [7:0] SUB_JOINT   = 8'h01;
  localparam logic [7:0] SUB_VERSION = 8'h02;

  localparam int JOINT_SLOTS     = 7;
  localparam int ANGLE_BYTES     = 2 * JOINT_SLOTS;
  localparam int ANGLE_FIRST_POS = 5;
  localparam int CNT_W           = 9;
  localparam int ANGLE_W         = 31;

  // round(pi * 2^24 / 1800)
  localparam logic signed [31:0] RAD_Q24_PER_TENTH_DEG = 32'sd29282;

  typedef enum logic [2:0] {
    KIND_JOINT   = 3'd0,
    KIND_VERSION = 3'd1,
    KIND_UPGRADE = 3'd2,
    KIND_OTHER   = 3'd3,
    KIND_IGNORED = 3'd4,
    KIND_ERROR   = 3'd5
  } frame_kind_t;

  typedef logic [JOINT_SLOTS-1:0][15:0] joint_raw_t;

  typedef struct packed {
    logic        hit;
    frame_kind_t kind;
    logic [7:0]  cmd;
    logic [7:0]  sub;
  } frame_res_t;

endpackage

`default_nettype wire

// ===== rtl/asfr_core.sv =====
// frame parser: byte count, header, length, checksum and angle byte store
// depends on asfr_pkg and arm_status_frame_receiver_defines.svh
`default_nettype none
`include "arm_status_frame_receiver_defines.svh"

module asfr_core #(
  parameter int MAX_COUNT = 255
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv_i,
  input  wire logic [7:0]         rx_byte_i,
  output asfr_pkg::frame_res_t    res_o,
  output asfr_pkg::joint_raw_t    raw_o
);
  import asfr_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       sub_r, sub_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             ck_r, ck_nxt;
  logic [7:0]       angle_r   [ANGLE_BYTES];
  logic [7:0]       angle_nxt [ANGLE_BYTES];

  logic             over;
  logic             in_frame;
  logic [CNT_W-1:0] chk_pos;
  logic [CNT_W-1:0] end_pos;
  logic             at_end;
  frame_kind_t      kind;

  always_comb begin
    over     = cnt_r >= CNT_W'(MAX_COUNT);
    in_frame = !over && (cnt_r != '0);
    len_nxt  = (in_frame && cnt_r == CNT_W'(2)) ? rx_byte_i : len_r;
    chk_pos  = {1'b0, len_nxt} + CNT_W'(3);
    end_pos  = {1'b0, len_nxt} + CNT_W'(4);
    at_end   = in_frame && (cnt_r >= CNT_W'(3)) && (cnt_r == end_pos);

    hdr_nxt = (in_frame && cnt_r == CNT_W'(1)) ? rx_byte_i : hdr_r;
    sub_nxt = (in_frame && cnt_r == CNT_W'(3)) ? rx_byte_i : sub_r;
    cmd_nxt = (in_frame && cnt_r == CNT_W'(4)) ? rx_byte_i : cmd_r;

    sum_nxt = sum_r;
    ck_nxt  = ck_r;
    if (in_frame && cnt_r == CNT_W'(2)) begin
      sum_nxt = '0;
    end else if (in_frame && cnt_r >= CNT_W'(3)) begin
      if (cnt_r < chk_pos) begin
        sum_nxt = sum_r + rx_byte_i;
      end else if (cnt_r == chk_pos) begin
        ck_nxt = (rx_byte_i == sum_r);
      end
    end

    for (int i = 0; i < ANGLE_BYTES; i++) begin
      angle_nxt[i] = (in_frame && cnt_r == CNT_W'(ANGLE_FIRST_POS + i)) ? rx_byte_i
                                                                       : angle_r[i];
    end

    if (over) begin
      cnt_nxt = '0;
    end else if (cnt_r == '0) begin
      cnt_nxt = (rx_byte_i == SYNC_BYTE) ? CNT_W'(1) : '0;
    end else if (at_end) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    priority if (hdr_nxt != HDR2_BYTE || rx_byte_i != TAIL_BYTE || !ck_nxt) begin
      kind = KIND_ERROR;
    end else if (cmd_nxt == CMD_UPGRADE) begin
      kind = KIND_UPGRADE;
    end else if (cmd_nxt == CMD_VERSION) begin
      kind = (sub_nxt == SUB_VERSION) ? KIND_VERSION : KIND_IGNORED;
    end else if (cmd_nxt == CMD_JOINT) begin
      kind = (sub_nxt == SUB_JOINT) ? KIND_JOINT : KIND_IGNORED;
    end else begin
      kind = KIND_OTHER;
    end

    res_o.hit  = at_end;
    res_o.kind = kind;
    res_o.cmd  = cmd_nxt;
    res_o.sub  = sub_nxt;

    for (int j = 0; j < JOINT_SLOTS; j++) begin
      raw_o[j] = {angle_nxt[2*j+1], angle_nxt[2*j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hdr_r <= '0;
      len_r <= '0;
      sub_r <= '0;
      cmd_r <= '0;
      sum_r <= '0;
      ck_r  <= 1'b0;
    end else if (adv_i) begin
      cnt_r <= cnt_nxt;
      hdr_r <= hdr_nxt;
      len_r <= len_nxt;
      sub_r <= sub_nxt;
      cmd_r <= cmd_nxt;
      sum_r <= sum_nxt;
      ck_r  <= ck_nxt;
    end
  end

  // angle store has no reset, undefined until written
  always_ff @(posedge clk) begin
    if (adv_i) begin
      for (int i = 0; i < ANGLE_BYTES; i++) begin
        angle_r[i] <= angle_nxt[i];
      end
    end
  end

  `ASFR_ASSERT_NEXT(a_end_clears_count, clk, rst_n, adv_i && res_o.hit, cnt_r == '0)
  `ASFR_ASSERT_NEXT(a_bad_sync_dropped, clk, rst_n, adv_i && cnt_r == '0 && rx_byte_i != SYNC_BYTE, cnt_r == '0)

endmodule

`default_nettype wire

// ===== rtl/arm_status_frame_receiver.sv =====
// bytes wait in in_byte_r; out_valid rises as a frame's last byte is processed
// throughput: one byte per cycle; a byte stalls only when it ends a frame and the
// output register is full and not being taken
// reset: synchronous active-low rst_n clears the parser state and both valid flags;
// the angle byte store is not reset
`default_nettype none
`include "arm_status_frame_receiver_defines.svh"

module arm_status_frame_receiver #(
  parameter int MAX_COUNT  = 255,
  parameter int NUM_JOINTS = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_rx_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_frame_kind,
  output logic [7:0]               out_command_code,
  output logic [7:0]               out_sub_code,
  output logic signed [30:0]       out_joint_a,
  output logic signed [30:0]       out_joint_b,
  output logic signed [30:0]       out_joint_c,
  output logic signed [30:0]       out_joint_d,
  output logic signed [30:0]       out_joint_e,
  output logic signed [30:0]       out_joint_f,
  output logic signed [30:0]       out_joint_g
);
  import asfr_pkg::*;

  logic                      in_valid_r;
  logic [7:0]                in_byte_r;
  logic                      out_valid_r;
  frame_kind_t               kind_r;
  logic [7:0]                cmd_r;
  logic [7:0]                sub_r;
  logic signed [ANGLE_W-1:0] joint_r   [JOINT_SLOTS];
  logic signed [ANGLE_W-1:0] joint_nxt [JOINT_SLOTS];

  frame_res_t                res;
  joint_raw_t                raw;
  logic                      out_free;
  logic                      proc_go;
  logic signed [31:0]        prod [JOINT_SLOTS];

  asfr_core #(
    .MAX_COUNT(MAX_COUNT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv_i    (proc_go),
    .rx_byte_i(in_byte_r),
    .res_o    (res),
    .raw_o    (raw)
  );

  assign out_free = !out_valid_r || out_ready;
  assign proc_go  = in_valid_r && (!res.hit || out_free);
  assign in_ready = !in_valid_r || proc_go;

  // tenth-degree to radians, exact product
  always_comb begin
    for (int j = 0; j < JOINT_SLOTS; j++) begin
      prod[j] = $signed({{16{raw[j][15]}}, raw[j]}) * RAD_Q24_PER_TENTH_DEG;
      joint_nxt[j] = (res.kind == KIND_JOINT && j < NUM_JOINTS) ? prod[j][ANGLE_W-1:0]
                                                                : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (proc_go && res.hit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (proc_go && res.hit) begin
      kind_r <= res.kind;
      cmd_r  <= res.cmd;
      sub_r  <= res.sub;
      for (int j = 0; j < JOINT_SLOTS; j++) begin
        joint_r[j] <= joint_nxt[j];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_kind   = kind_r;
  assign out_command_code = cmd_r;
  assign out_sub_code     = sub_r;
  assign out_joint_a      = joint_r[0];
  assign out_joint_b      = joint_r[1];
  assign out_joint_c      = joint_r[2];
  assign out_joint_d      = joint_r[3];
  assign out_joint_e      = joint_r[4];
  assign out_joint_f      = joint_r[5];
  assign out_joint_g      = joint_r[6];

  `ASFR_ASSERT_NOW(a_joints_zero, clk, rst_n, out_valid_r && kind_r != KIND_JOINT, joint_r[0] == '0 && joint_r[6] == '0)
  `ASFR_ASSERT_NEXT(a_held_byte_kept, clk, rst_n, in_valid_r && !proc_go, in_valid_r && $stable(in_byte_r))

endmodule

`default_nettype wire

// ===== sim/arm_status_frame_checker.sv =====
// checker for the arm status frame receiver: watches both channels, rebuilds each frame
// from the accepted bytes and compares every frame report field by field
// depends on asfr_pkg
module arm_status_frame_checker #(
  parameter int MAX_COUNT  = 255,
  parameter int NUM_JOINTS = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [7:0]               in_rx_byte,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [2:0]               out_frame_kind,
  input  logic [7:0]               out_command_code,
  input  logic [7:0]               out_sub_code,
  input  logic signed [asfr_pkg::ANGLE_W-1:0] out_joint_a,
  input  logic signed [asfr_pkg::ANGLE_W-1:0] out_joint_b,
  input  logic signed [asfr_pkg::ANGLE_W-1:0] out_joint_c,
  input  logic signed [asfr_pkg::ANGLE_W-1:0] out_joint_d,
  input  logic signed [asfr_pkg::ANGLE_W-1:0] out_joint_e,
  input  logic signed [asfr_pkg::ANGLE_W-1:0] out_joint_f,
  input  logic signed [asfr_pkg::ANGLE_W-1:0] out_joint_g,
  output int                       failures,
  output int                       outstanding,
  output int                       reports_checked
);
  import asfr_pkg::*;

  typedef struct packed {
    frame_kind_t                          kind;
    logic [7:0]                           cmd;
    logic [7:0]                           sub;
    logic [JOINT_SLOTS-1:0][ANGLE_W-1:0]  joints;
  } frame_report_t;

  frame_report_t expected_reports [$];

  logic [CNT_W-1:0] byte_pos;
  logic [7:0]       hdr2_seen;
  logic [7:0]       frame_len;
  logic [7:0]       sub_seen;
  logic [7:0]       cmd_seen;
  logic [7:0]       sum_acc;
  logic             sum_match;
  logic [7:0]       angle_store [ANGLE_BYTES];

  string joint_names [JOINT_SLOTS] = '{"joint_a", "joint_b", "joint_c", "joint_d",
                                       "joint_e", "joint_f", "joint_g"};

  task automatic take_byte(input logic [7:0] b);
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  len;
    logic [3:0]        slot;
    logic signed [15:0] raw;
    logic signed [47:0] prod;
    frame_report_t     rep;
    pos = byte_pos;
    len = {1'b0, frame_len};
    if (pos >= MAX_COUNT) begin
      byte_pos = '0;
      return;
    end
    if (pos == 0) begin
      if (b == SYNC_BYTE) byte_pos = CNT_W'(1);
      return;
    end
    if (pos == 1) hdr2_seen = b;
    if (pos == 2) begin
      frame_len = b;
      len = {1'b0, b};
      sum_acc = '0;
    end
    if (pos == 3) sub_seen = b;
    if (pos == 4) cmd_seen = b;
    if (pos >= ANGLE_FIRST_POS && pos < ANGLE_FIRST_POS + ANGLE_BYTES) begin
      slot = 4'(pos - CNT_W'(ANGLE_FIRST_POS));
      angle_store[slot] = b;
    end
    if (pos >= 3) begin
      if (pos < len + 3) sum_acc = sum_acc + b;
      else if (pos == len + 3) sum_match = (b == sum_acc);
    end
    byte_pos = pos + 1'b1;
    if (pos < 3 || pos != len + 4) return;

    byte_pos = '0;
    if (hdr2_seen != HDR2_BYTE || b != TAIL_BYTE || !sum_match) rep.kind = KIND_ERROR;
    else if (cmd_seen == CMD_UPGRADE) rep.kind = KIND_UPGRADE;
    else if (cmd_seen == CMD_VERSION)
      rep.kind = (sub_seen == SUB_VERSION) ? KIND_VERSION : KIND_IGNORED;
    else if (cmd_seen == CMD_JOINT)
      rep.kind = (sub_seen == SUB_JOINT) ? KIND_JOINT : KIND_IGNORED;
    else rep.kind = KIND_OTHER;
    rep.cmd = cmd_seen;
    rep.sub = sub_seen;
    for (int j = 0; j < JOINT_SLOTS; j++) begin
      raw = {angle_store[2*j+1], angle_store[2*j]};
      prod = raw * RAD_Q24_PER_TENTH_DEG;
      rep.joints[j] = (rep.kind == KIND_JOINT && j < NUM_JOINTS) ? prod[ANGLE_W-1:0] : '0;
    end
    expected_reports.push_back(rep);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : track
    frame_report_t      want;
    logic signed [ANGLE_W-1:0] got [JOINT_SLOTS];
    if (!rst_n) begin
      expected_reports.delete();
      byte_pos = '0;
      hdr2_seen = '0;
      frame_len = '0;
      sub_seen = '0;
      cmd_seen = '0;
      sum_acc = '0;
      sum_match = 1'b0;
      failures = 0;
      reports_checked = 0;
    end else begin
      if (in_valid && in_ready) take_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("frame report with no frame pending, kind %0d", out_frame_kind);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          got = '{out_joint_a, out_joint_b, out_joint_c, out_joint_d,
                  out_joint_e, out_joint_f, out_joint_g};
          report_field("frame_kind", want.kind, out_frame_kind);
          report_field("command_code", want.cmd, out_command_code);
          report_field("sub_code", want.sub, out_sub_code);
          for (int j = 0; j < JOINT_SLOTS; j++)
            report_field(joint_names[j], $signed(want.joints[j]), got[j]);
          reports_checked++;
        end
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

// ===== sim/arm_status_frame_receiver_test.sv =====
// testbench top for the arm status frame receiver: drives directed and random byte
// streams through the handshake and gives the verdict
// depends on asfr_pkg, arm_status_frame_receiver and arm_status_frame_checker
module arm_status_frame_receiver_test;
  import asfr_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_frame_kind;
  logic [7:0] out_command_code;
  logic [7:0] out_sub_code;
  logic signed [ANGLE_W-1:0] out_joint_a, out_joint_b, out_joint_c, out_joint_d;
  logic signed [ANGLE_W-1:0] out_joint_e, out_joint_f, out_joint_g;

  int failures;
  int outstanding;
  int reports_checked;
  int bytes_sent = 0;
  int send_idle_pct = 34;
  int recv_idle_pct = 87;
  logic [7:0] payload [$];

  always #10 clk = ~clk;

  arm_status_frame_receiver i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_kind  (out_frame_kind),
    .out_command_code(out_command_code),
    .out_sub_code    (out_sub_code),
    .out_joint_a     (out_joint_a),
    .out_joint_b     (out_joint_b),
    .out_joint_c     (out_joint_c),
    .out_joint_d     (out_joint_d),
    .out_joint_e     (out_joint_e),
    .out_joint_f     (out_joint_f),
    .out_joint_g     (out_joint_g)
  );

  arm_status_frame_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_kind  (out_frame_kind),
    .out_command_code(out_command_code),
    .out_sub_code    (out_sub_code),
    .out_joint_a     (out_joint_a),
    .out_joint_b     (out_joint_b),
    .out_joint_c     (out_joint_c),
    .out_joint_d     (out_joint_d),
    .out_joint_e     (out_joint_e),
    .out_joint_f     (out_joint_f),
    .out_joint_g     (out_joint_g),
    .failures        (failures),
    .outstanding     (outstanding),
    .reports_checked (reports_checked)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic set_payload(input logic [7:0] sub, input logic [7:0] cmd);
    payload.delete();
    payload.push_back(sub);
    payload.push_back(cmd);
  endtask

  task automatic add_angle(input logic [15:0] a);
    payload.push_back(a[7:0]);
    payload.push_back(a[15:8]);
  endtask

  task automatic send_frame(input logic [7:0] hdr2, input logic [7:0] csum_flip,
                            input logic [7:0] tail);
    logic [7:0] sum;
    sum = '0;
    foreach (payload[k]) sum += payload[k];
    send_byte(SYNC_BYTE);
    send_byte(hdr2);
    send_byte(8'(payload.size()));
    foreach (payload[k]) send_byte(payload[k]);
    send_byte(sum ^ csum_flip);
    send_byte(tail);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random_frame;
    int pick;
    logic [7:0] hdr2;
    logic [7:0] flip;
    logic [7:0] tail;
    logic [15:0] a;
    pick = $urandom_range(99);
    hdr2 = HDR2_BYTE;
    flip = 8'h00;
    tail = TAIL_BYTE;
    if (pick < 6) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      return;
    end
    if (pick == 6) begin
      // runs past the byte counter limit
      payload.delete();
      repeat ($urandom_range(251, 255)) payload.push_back(8'($urandom_range(255)));
    end else if (pick < 12) begin
      payload.delete();
      if ($urandom_range(1))
        payload.push_back($urandom_range(1) ? CMD_UPGRADE : 8'($urandom_range(255)));
    end else if (pick < 52) begin
      set_payload(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : SUB_JOINT, CMD_JOINT);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(11)) payload.push_back(8'($urandom_range(255)));
      end else begin
        repeat (JOINT_SLOTS) begin
          case ($urandom_range(5))
            0: a = 16'h8000;
            1: a = 16'h7FFF;
            2: a = 16'h0000;
            3: a = 16'hFFFF;
            default: a = 16'($urandom);
          endcase
          add_angle(a);
        end
        repeat ($urandom_range(3)) payload.push_back(8'($urandom_range(255)));
      end
    end else if (pick < 62) begin
      set_payload(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : SUB_VERSION,
                  CMD_VERSION);
      repeat ($urandom_range(6)) payload.push_back(8'($urandom_range(255)));
    end else if (pick < 70) begin
      set_payload(8'($urandom_range(255)), CMD_UPGRADE);
      repeat ($urandom_range(6)) payload.push_back(8'($urandom_range(255)));
    end else begin
      set_payload(8'($urandom_range(255)), 8'($urandom_range(255)));
      repeat ($urandom_range(18)) payload.push_back(8'($urandom_range(255)));
    end
    case ($urandom_range(19))
      0: begin
        hdr2 = 8'($urandom_range(255));
        if (hdr2 == HDR2_BYTE) hdr2 = 8'h00;
      end
      1: flip = 8'($urandom_range(1, 255));
      2: tail = 8'($urandom_range(255));
      default: ;
    endcase
    send_frame(hdr2, flip, tail);
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // bad start bytes, then a full joint frame so every angle byte is written
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR2_BYTE);
    set_payload(SUB_JOINT, CMD_JOINT);
    add_angle(16'h8000);
    add_angle(16'h7FFF);
    add_angle(16'h0000);
    add_angle(16'hFFFF);
    add_angle(16'h0001);
    add_angle(16'h0384);
    add_angle(16'hFC7C);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(SUB_JOINT, CMD_JOINT);
    repeat (6) add_angle(16'h1234);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(SUB_JOINT, CMD_JOINT);
    add_angle(16'h8001);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(SUB_VERSION, CMD_VERSION);
    payload.push_back(8'h33);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(8'h05, CMD_VERSION);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(8'h03, CMD_JOINT);
    add_angle(16'h7FFF);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(8'h00, CMD_UPGRADE);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(8'hFF, 8'hFF);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    payload.delete();
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    payload.push_back(CMD_UPGRADE);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);
    set_payload(SUB_JOINT, CMD_JOINT);
    add_angle(16'h0100);
    send_frame(8'hAB, 8'h00, TAIL_BYTE);
    send_frame(HDR2_BYTE, 8'h01, TAIL_BYTE);
    send_frame(HDR2_BYTE, 8'h00, 8'h7C);
    payload.delete();
    repeat (255) payload.push_back(8'h00);
    send_frame(HDR2_BYTE, 8'h00, TAIL_BYTE);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 34 : 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 450) send_random_frame();
      drain();
    end

    repeat (8) @(posedge clk);
    if (outstanding != 0) $error("%0d frame reports never arrived", outstanding);
    $display("covered %0d bytes and %0d frame reports over three idling mixes",
             bytes_sent, reports_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $error("no handshake for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== arm_status_frame_receiver.f =====
+incdir+rtl
rtl/asfr_pkg.sv
rtl/asfr_core.sv
rtl/arm_status_frame_receiver.sv
sim/arm_status_frame_checker.sv
sim/arm_status_frame_receiver_test.sv
